### rtl/tqpc_pkg.sv
// ----------------------------------------------------------------------------
// tqpc_pkg
// Shared types and constants for the two-queue page cache policy.
// ----------------------------------------------------------------------------
package tqpc_pkg;

  // Region code held per entry and reported per access.
  typedef enum logic [1:0] {
    RGN_EMPTY = 2'd0,
    RGN_MAIN  = 2'd1,
    RGN_IN    = 2'd2,
    RGN_OUT   = 2'd3
  } region_e;

  localparam int unsigned CAP_BITS   = 7;
  localparam int unsigned COUNT_BITS = 32;
  localparam int unsigned CAP_MIN    = 10;
  localparam int unsigned CAP_RESET  = 64;

  // floor(n / 10) == (n * 205) >> 11 for every n below 1029
  localparam int unsigned DIV10_MUL   = 205;
  localparam int unsigned DIV10_SHIFT = 11;

endpackage

### rtl/tqpc_in_if.sv
// ----------------------------------------------------------------------------
// tqpc_in_if
// Access channel: one page key per transfer.
// ----------------------------------------------------------------------------
interface tqpc_in_if #(
  parameter int KEY_BITS = 32
);
  logic                       valid;
  logic                       ready;
  logic signed [KEY_BITS-1:0] page_key;
  logic                       is_last;

  modport source (output valid, output page_key, output is_last, input ready);
  modport sink   (input valid, input page_key, input is_last, output ready);
endinterface

### rtl/tqpc_out_if.sv
// ----------------------------------------------------------------------------
// tqpc_out_if
// Result channel: hit flag, region hit, running hit count.
// ----------------------------------------------------------------------------
interface tqpc_out_if;
  logic                                 valid;
  logic                                 ready;
  logic                                 hit;
  tqpc_pkg::region_e                    hit_region;
  logic [tqpc_pkg::COUNT_BITS-1:0]      hit_count;
  logic                                 is_final;

  modport source (output valid, output hit, output hit_region, output hit_count,
                  output is_final, input ready);
  modport sink   (input valid, input hit, input hit_region, input hit_count,
                  input is_final, output ready);
endinterface

### rtl/two_queue_page_cache_policy.sv
// ----------------------------------------------------------------------------
// two_queue_page_cache_policy
// 2Q replacement policy over main, in and out regions with a parallel tag
// compare across all entries.
// ----------------------------------------------------------------------------
// Pipeline: an access loads the input register, then, once the result
//   register is free, its lookup result loads the result register.
// Throughput: one access per cycle while results are taken; the lookup and
//   region update is a single pass through the entry array between these regs.
// Reset: all entries empty, region fills and hit count zero, capacity 64.
// A capacity write empties every region in that cycle; hit count is kept.
// ----------------------------------------------------------------------------
module two_queue_page_cache_policy #(
  parameter int MAX_ENTRIES = 64,
  parameter int KEY_BITS    = 32
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              cfg_we_i,
  input  logic [tqpc_pkg::CAP_BITS-1:0]     cfg_wdata_i,
  tqpc_in_if.sink                           in_i,
  tqpc_out_if.source                        out_o
);

  localparam int RW     = $clog2(MAX_ENTRIES);      // rank / index width
  localparam int FW     = $clog2(MAX_ENTRIES + 1);  // fill count width
  localparam int CW     = tqpc_pkg::CAP_BITS;
  localparam int CapMax = (MAX_ENTRIES > 127) ? 127 : MAX_ENTRIES;
  localparam int PW     = CW + 8;                    // reciprocal product width

  // Effective total: written capacity clamped to [10, MAX_ENTRIES], top at most 127.
  function automatic logic [CW-1:0] clamp_total(input logic [CW-1:0] cap);
    logic [CW-1:0] t;
    t = cap;
    if (cap < CW'(tqpc_pkg::CAP_MIN)) t = CW'(tqpc_pkg::CAP_MIN);
    if (t > CW'(CapMax))              t = CW'(CapMax);
    return t;
  endfunction

  // floor(t/10)*2 via multiply by reciprocal.
  function automatic logic [CW-1:0] part_size(input logic [CW-1:0] t);
    logic [PW-1:0] prod;
    prod = PW'(t) * PW'(tqpc_pkg::DIV10_MUL);
    return CW'(prod >> tqpc_pkg::DIV10_SHIFT) << 1;
  endfunction

  function automatic logic [CW-1:0] out_size(input logic [CW-1:0] t);
    return t - (part_size(t) << 1);
  endfunction

  // --------------------------------------------------------------------------
  // Region sizes, loaded on a capacity write.
  // --------------------------------------------------------------------------
  logic [FW-1:0] size_part_q, size_out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      size_part_q <= FW'(part_size(clamp_total(CW'(tqpc_pkg::CAP_RESET))));
      size_out_q  <= FW'(out_size(clamp_total(CW'(tqpc_pkg::CAP_RESET))));
    end else if (cfg_we_i) begin
      size_part_q <= FW'(part_size(clamp_total(cfg_wdata_i)));
      size_out_q  <= FW'(out_size(clamp_total(cfg_wdata_i)));
    end
  end

  // --------------------------------------------------------------------------
  // Input register and result register handshake.
  // --------------------------------------------------------------------------
  logic                s1_valid_q;
  logic [KEY_BITS-1:0] s1_key_q;
  logic                s1_last_q;
  logic                out_free;
  logic                fire;       // access in s1 is resolved this cycle
  logic                in_xfer;

  assign out_free   = !out_o.valid || out_o.ready;
  assign fire       = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_xfer    = in_i.valid && in_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (in_xfer) begin
      s1_valid_q <= 1'b1;
    end else if (fire) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      s1_key_q  <= in_i.page_key;
      s1_last_q <= in_i.is_last;
    end
  end

  // --------------------------------------------------------------------------
  // Entry store: region codes reset to empty; key and rank only read while
  // the entry is in use.
  // --------------------------------------------------------------------------
  tqpc_pkg::region_e   region_q [MAX_ENTRIES];
  tqpc_pkg::region_e   region_d [MAX_ENTRIES];
  logic [RW-1:0]       rank_q   [MAX_ENTRIES];
  logic [RW-1:0]       rank_d   [MAX_ENTRIES];
  logic [KEY_BITS-1:0] key_mem  [MAX_ENTRIES];

  logic [FW-1:0] fill_main_q, fill_in_q, fill_out_q;
  logic [FW-1:0] fill_main_d, fill_in_d, fill_out_d;

  logic [tqpc_pkg::COUNT_BITS-1:0] hit_cnt_q, hit_cnt_d;

  // Per-entry match and candidate vectors.
  logic [MAX_ENTRIES-1:0] match_v, hit_oh;
  logic [MAX_ENTRIES-1:0] old_main_v, old_in_v, old_out_v;
  logic [MAX_ENTRIES-1:0] old_main_oh, old_in_oh, old_out_oh;
  logic [MAX_ENTRIES-1:0] empty_v, ins_oh;
  logic [MAX_ENTRIES-1:0] main_v, inr_v, outr_v;

  logic              found;
  logic [1:0]        fr_bits;
  tqpc_pkg::region_e fr;
  logic [RW-1:0]     frk;
  logic              full_main, full_in, full_out;
  logic              evict, drop_out, drop_main, ins_found;

  always_comb begin
    fr_bits = '0;
    frk     = '0;
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      match_v[k]    = (region_q[k] != tqpc_pkg::RGN_EMPTY) && (key_mem[k] == s1_key_q);
      main_v[k]     = (region_q[k] == tqpc_pkg::RGN_MAIN);
      inr_v[k]      = (region_q[k] == tqpc_pkg::RGN_IN);
      outr_v[k]     = (region_q[k] == tqpc_pkg::RGN_OUT);
      old_main_v[k] = main_v[k] && (FW'(rank_q[k]) + FW'(1) == fill_main_q);
      old_in_v[k]   = inr_v[k]  && (FW'(rank_q[k]) + FW'(1) == fill_in_q);
      old_out_v[k]  = outr_v[k] && (FW'(rank_q[k]) + FW'(1) == fill_out_q);
    end

    // lowest set bit of each candidate vector
    hit_oh      = match_v & (~match_v + 1'b1);
    old_main_oh = old_main_v & (~old_main_v + 1'b1);
    old_in_oh   = old_in_v & (~old_in_v + 1'b1);
    old_out_oh  = old_out_v & (~old_out_v + 1'b1);

    for (int k = 0; k < MAX_ENTRIES; k++) begin
      fr_bits = fr_bits | (hit_oh[k] ? 2'(region_q[k]) : 2'b00);
      frk     = frk | (hit_oh[k] ? rank_q[k] : '0);
    end
    found = |match_v;
    fr    = tqpc_pkg::region_e'(fr_bits);

    full_main = fill_main_q >= size_part_q;
    full_in   = fill_in_q >= size_part_q;
    full_out  = fill_out_q >= size_out_q;

    evict     = !found && full_in && (|old_in_oh);
    drop_out  = evict && full_out && (|old_out_oh);
    drop_main = found && (fr == tqpc_pkg::RGN_OUT) && full_main && (|old_main_oh);

    // free slots after the out region has dropped its oldest page
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      empty_v[k] = (region_q[k] == tqpc_pkg::RGN_EMPTY) || (drop_out && old_out_oh[k]);
    end
    ins_oh    = found ? '0 : (empty_v & (~empty_v + 1'b1));
    ins_found = |ins_oh;

    // per-entry region and rank update
    for (int k = 0; k < MAX_ENTRIES; k++) begin
      region_d[k] = region_q[k];
      rank_d[k]   = rank_q[k];
      if (found) begin
        unique case (fr)
          tqpc_pkg::RGN_MAIN, tqpc_pkg::RGN_IN: begin
            if (hit_oh[k]) begin
              rank_d[k] = '0;
            end else if (region_q[k] == fr && rank_q[k] < frk) begin
              rank_d[k] = rank_q[k] + RW'(1);
            end
          end
          tqpc_pkg::RGN_OUT: begin
            if (hit_oh[k]) begin
              region_d[k] = tqpc_pkg::RGN_MAIN;
              rank_d[k]   = '0;
            end else if (outr_v[k] && rank_q[k] > frk) begin
              rank_d[k] = rank_q[k] - RW'(1);
            end else if (main_v[k]) begin
              if (drop_main && old_main_oh[k]) begin
                region_d[k] = tqpc_pkg::RGN_EMPTY;
              end else begin
                rank_d[k] = rank_q[k] + RW'(1);
              end
            end
          end
          default: ;
        endcase
      end else begin
        if (ins_oh[k]) begin
          region_d[k] = tqpc_pkg::RGN_IN;
          rank_d[k]   = '0;
        end else if (evict && old_in_oh[k]) begin
          region_d[k] = tqpc_pkg::RGN_OUT;
          rank_d[k]   = '0;
        end else if (evict && outr_v[k]) begin
          if (drop_out && old_out_oh[k]) begin
            region_d[k] = tqpc_pkg::RGN_EMPTY;
          end else begin
            rank_d[k] = rank_q[k] + RW'(1);
          end
        end else if (inr_v[k] && ins_found) begin
          rank_d[k] = rank_q[k] + RW'(1);
        end
      end
    end

    // region fill counts
    fill_main_d = fill_main_q;
    fill_in_d   = fill_in_q;
    fill_out_d  = fill_out_q;
    if (found) begin
      if (fr == tqpc_pkg::RGN_OUT) begin
        if (fill_out_q != '0) fill_out_d = fill_out_q - FW'(1);
        if (!drop_main)       fill_main_d = fill_main_q + FW'(1);
      end
    end else begin
      fill_in_d = fill_in_q - FW'(evict) + FW'(ins_found);
      if (evict && !drop_out) fill_out_d = fill_out_q + FW'(1);
    end

    // saturating hit count
    hit_cnt_d = hit_cnt_q;
    if (found && hit_cnt_q != '1) hit_cnt_d = hit_cnt_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k < MAX_ENTRIES; k++) region_q[k] <= tqpc_pkg::RGN_EMPTY;
      fill_main_q <= '0;
      fill_in_q   <= '0;
      fill_out_q  <= '0;
      hit_cnt_q   <= '0;
    end else if (cfg_we_i) begin
      // capacity change empties every region
      for (int k = 0; k < MAX_ENTRIES; k++) region_q[k] <= tqpc_pkg::RGN_EMPTY;
      fill_main_q <= '0;
      fill_in_q   <= '0;
      fill_out_q  <= '0;
    end else if (fire) begin
      region_q    <= region_d;
      fill_main_q <= fill_main_d;
      fill_in_q   <= fill_in_d;
      fill_out_q  <= fill_out_d;
      hit_cnt_q   <= hit_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      rank_q <= rank_d;
      for (int k = 0; k < MAX_ENTRIES; k++) begin
        if (ins_oh[k]) key_mem[k] <= s1_key_q;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Result register: holds until the sink takes the transfer.
  // --------------------------------------------------------------------------
  logic                            out_valid_q;
  logic                            out_hit_q;
  tqpc_pkg::region_e               out_region_q;
  logic [tqpc_pkg::COUNT_BITS-1:0] out_count_q;
  logic                            out_final_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_free) begin
      out_valid_q <= s1_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_hit_q    <= found;
      out_region_q <= found ? fr : tqpc_pkg::RGN_EMPTY;
      out_count_q  <= hit_cnt_d;
      out_final_q  <= s1_last_q;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.hit        = out_hit_q;
  assign out_o.hit_region = out_region_q;
  assign out_o.hit_count  = out_count_q;
  assign out_o.is_final   = out_final_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_fill_le_size: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fill_main_q <= size_part_q && fill_in_q <= size_part_q && fill_out_q <= size_out_q)
    else $error("region fill exceeds its size");

  a_fill_matches_entries: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(main_v) == int'(fill_main_q) && $countones(inr_v) == int'(fill_in_q) &&
    $countones(outr_v) == int'(fill_out_q))
    else $error("fill count disagrees with entry regions");

  a_single_match: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_valid_q |-> $onehot0(match_v))
    else $error("page key present in more than one entry");

  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    fire |=> out_valid_q)
    else $error("resolved access produced no result");

endmodule

### tb/tqpc_checker.sv
// ----------------------------------------------------------------------------
// tqpc_checker
// Watches the access, result and capacity ports, keeps its own 2Q region
// model and checks every result transfer against the oldest prediction.
// ----------------------------------------------------------------------------
module tqpc_checker #(
  parameter int SLOTS = 64
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [tqpc_pkg::CAP_BITS-1:0] cfg_wdata_i,
  tqpc_in_if                            acc_i,
  tqpc_out_if                           res_i,
  output int                            err_count_o,
  output int                            pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CW = tqpc_pkg::CAP_BITS;

  typedef struct {
    logic                            hit;
    tqpc_pkg::region_e               rgn;
    logic [tqpc_pkg::COUNT_BITS-1:0] count;
    logic                            fin;
  } access_result_t;

  // region model
  logic [31:0]                     slot_key  [SLOTS];
  tqpc_pkg::region_e               slot_rgn  [SLOTS];
  int unsigned                     slot_rank [SLOTS];
  int unsigned                     rgn_fill  [4];
  logic [tqpc_pkg::COUNT_BITS-1:0] hit_total;
  logic [CW-1:0]                   cap_q;

  access_result_t expected_results [$];

  function automatic void clear_regions();
    for (int k = 0; k < SLOTS; k++) begin
      slot_rgn[k]  = tqpc_pkg::RGN_EMPTY;
      slot_rank[k] = 0;
    end
    for (int r = 0; r < 4; r++) rgn_fill[r] = 0;
  endfunction

  function automatic int unsigned clamped_capacity();
    int unsigned t;
    t = cap_q;
    if (t < tqpc_pkg::CAP_MIN) t = tqpc_pkg::CAP_MIN;
    if (t > SLOTS) t = SLOTS;
    return t;
  endfunction

  // main and in get floor(total/10)*2 each, out takes the remainder
  function automatic int unsigned region_limit(tqpc_pkg::region_e r);
    int unsigned t;
    int unsigned part;
    t    = clamped_capacity();
    part = t / 10 * 2;
    return (r == tqpc_pkg::RGN_OUT) ? t - 2 * part : part;
  endfunction

  function automatic void detach_slot(int i);
    tqpc_pkg::region_e r;
    r = slot_rgn[i];
    for (int k = 0; k < SLOTS; k++)
      if (slot_rgn[k] == r && slot_rank[k] > slot_rank[i]) slot_rank[k]--;
    if (rgn_fill[r] > 0) rgn_fill[r]--;
    slot_rgn[i] = tqpc_pkg::RGN_EMPTY;
  endfunction

  function automatic void attach_front(int i, tqpc_pkg::region_e r);
    for (int k = 0; k < SLOTS; k++)
      if (slot_rgn[k] == r) slot_rank[k]++;
    slot_rgn[i]  = r;
    slot_rank[i] = 0;
    rgn_fill[r]++;
  endfunction

  function automatic int oldest_in(tqpc_pkg::region_e r);
    for (int k = 0; k < SLOTS; k++)
      if (slot_rgn[k] == r && slot_rank[k] + 1 == rgn_fill[r]) return k;
    return -1;
  endfunction

  function automatic void evict_if_full(tqpc_pkg::region_e r);
    int j;
    if (rgn_fill[r] >= region_limit(r)) begin
      j = oldest_in(r);
      if (j >= 0) detach_slot(j);
    end
  endfunction

  function automatic access_result_t lookup_and_update(logic [31:0] key, logic last);
    int                found;
    int                j;
    bit                placed;
    tqpc_pkg::region_e r;
    access_result_t    res;
    found  = -1;
    placed = 1'b0;
    r      = tqpc_pkg::RGN_EMPTY;
    for (int k = 0; k < SLOTS; k++)
      if (found < 0 && slot_rgn[k] != tqpc_pkg::RGN_EMPTY && slot_key[k] == key) found = k;

    if (found >= 0) begin
      r = slot_rgn[found];
      detach_slot(found);
      if (r == tqpc_pkg::RGN_OUT) begin
        // promoted into main, main's oldest makes room
        evict_if_full(tqpc_pkg::RGN_MAIN);
        attach_front(found, tqpc_pkg::RGN_MAIN);
      end else begin
        attach_front(found, r);
      end
      if (hit_total != '1) hit_total++;
    end else begin
      if (rgn_fill[tqpc_pkg::RGN_IN] >= region_limit(tqpc_pkg::RGN_IN)) begin
        j = oldest_in(tqpc_pkg::RGN_IN);
        if (j >= 0) begin
          detach_slot(j);
          evict_if_full(tqpc_pkg::RGN_OUT);
          attach_front(j, tqpc_pkg::RGN_OUT);
        end
      end
      for (int k = 0; k < SLOTS; k++) begin
        if (!placed && slot_rgn[k] == tqpc_pkg::RGN_EMPTY) begin
          slot_key[k] = key;
          attach_front(k, tqpc_pkg::RGN_IN);
          placed = 1'b1;
        end
      end
    end

    res.hit   = (found >= 0);
    res.rgn   = r;
    res.count = hit_total;
    res.fin   = last;
    return res;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    access_result_t want;
    if (!rst_ni) begin
      cap_q       = CW'(tqpc_pkg::CAP_RESET);
      hit_total   = '0;
      err_count_o = 0;
      clear_regions();
      expected_results.delete();
    end else begin
      if (cfg_we_i) begin
        cap_q = cfg_wdata_i;
        clear_regions();
      end
      if (acc_i.valid && acc_i.ready)
        expected_results.push_back(lookup_and_update(acc_i.page_key, acc_i.is_last));
      if (res_i.valid && res_i.ready) begin
        if (expected_results.size() == 0) begin
          $error("result transfer with no access outstanding");
          err_count_o++;
        end else begin
          want = expected_results.pop_front();
          if (res_i.hit !== want.hit) begin
            $error("hit: expected %0d, actual %0d", want.hit, res_i.hit);
            err_count_o++;
          end
          if (res_i.hit_region !== want.rgn) begin
            $error("hit_region: expected %0d, actual %0d", want.rgn, res_i.hit_region);
            err_count_o++;
          end
          if (res_i.hit_count !== want.count) begin
            $error("hit_count: expected %0d, actual %0d", want.count, res_i.hit_count);
            err_count_o++;
          end
          if (res_i.is_final !== want.fin) begin
            $error("is_final: expected %0d, actual %0d", want.fin, res_i.is_final);
            err_count_o++;
          end
        end
      end
    end
    pending_o = expected_results.size();
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the two-queue page cache policy. A short directed
// run walks every hit region, the key extremes and the capacity clamp, then
// random phases over several capacities reuse small key pools so pages cycle
// through in, out and main. Both handshake sides idle at varied rates and
// one phase holds results off long enough to back up the access port.
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam int SLOTS        = 64;
  localparam int PHASE_ITEMS  = 100;
  localparam int NUM_PHASES   = 8;
  localparam int HOLD_CYCLES  = 300;  // long result stall in the pressure phase
  localparam int PRESSURE_PH  = 4;

  logic                          clk;
  logic                          rst_n;
  logic                          cfg_we;
  logic [tqpc_pkg::CAP_BITS-1:0] cfg_wdata;
  int                            err_count;
  int                            pending;

  idle_mode_e idle_mode    = IDLE_NONE;
  bit         hold_request = 1'b0;

  // page keys reused within a phase so that hits actually happen
  logic [31:0] key_pool [SLOTS * 3 / 2];

  tqpc_in_if #(.KEY_BITS(32)) acc_if ();
  tqpc_out_if                 res_if ();

  two_queue_page_cache_policy #(
    .MAX_ENTRIES (SLOTS),
    .KEY_BITS    (32)
  ) u_dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .in_i        (acc_if),
    .out_o       (res_if)
  );

  tqpc_checker #(.SLOTS(SLOTS)) u_checker (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .acc_i       (acc_if),
    .res_i       (res_if),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Hard stop well past the slowest legal run.
  initial begin
    #5_000_000;
    $display("tb: errors");
    $finish;
  end

  // Result side: ready pattern follows the idle mode; a hold request takes
  // ready low for a fixed stretch, counted here cycle by cycle.
  initial begin : result_sink
    int unsigned hold_left;
    int unsigned pct;
    hold_left = 0;
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left != 0) begin
        hold_left--;
        res_if.ready <= 1'b0;
      end else if (hold_request) begin
        hold_request = 1'b0;
        hold_left    = HOLD_CYCLES - 1;
        res_if.ready <= 1'b0;
      end else begin
        case (idle_mode)
          IDLE_RECV: pct = 81;
          IDLE_BOTH: pct = 7;
          default:   pct = 0;
        endcase
        res_if.ready <= ($urandom_range(99) >= pct);
      end
    end
  end

  // One access transfer. Gaps go in front of the item; valid stays high
  // straight into the next item when no gap is drawn.
  task automatic send_access(input logic [31:0] key, input logic last);
    int unsigned pct;
    case (idle_mode)
      IDLE_SEND: pct = 81;
      IDLE_BOTH: pct = 7;
      default:   pct = 0;
    endcase
    while ($urandom_range(99) < pct) begin
      acc_if.valid <= 1'b0;
      @(posedge clk);
    end
    acc_if.valid    <= 1'b1;
    acc_if.page_key <= key;
    acc_if.is_last  <= last;
    do @(posedge clk); while (!acc_if.ready);
  endtask

  // Drop valid and wait until every predicted result has been taken.
  task automatic drain_results();
    acc_if.valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  // Capacity write; only called with the block drained. Every access yields a
  // result, so an empty prediction queue means the pipeline is empty too.
  task automatic write_capacity(input logic [tqpc_pkg::CAP_BITS-1:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  // Random phase: hot subset of the pool for main/in hits, the whole pool
  // (half again the capacity) so pages age through out, and a few fresh keys.
  task automatic run_phase(input logic [tqpc_pkg::CAP_BITS-1:0] cap, input int n_items);
    int unsigned eff;
    int unsigned pool_n;
    int unsigned hot_n;
    int unsigned sel;
    logic [31:0] key;
    logic        last;
    eff = cap;
    if (eff < tqpc_pkg::CAP_MIN) eff = tqpc_pkg::CAP_MIN;
    if (eff > SLOTS) eff = SLOTS;
    pool_n = eff * 3 / 2;
    hot_n  = pool_n / 5;
    for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom();
    for (int n = 0; n < n_items; n++) begin
      sel = $urandom_range(99);
      if (sel < 40)      key = key_pool[$urandom_range(hot_n - 1)];
      else if (sel < 90) key = key_pool[$urandom_range(pool_n - 1)];
      else               key = $urandom();
      last = (n == n_items - 1) || ($urandom_range(31) == 0);
      send_access(key, last);
    end
    drain_results();
  endtask

  initial begin : stimulus
    logic [tqpc_pkg::CAP_BITS-1:0] phase_cap  [NUM_PHASES];
    idle_mode_e                    phase_mode [NUM_PHASES];

    // capacities include both clamp directions and the exact bounds
    phase_cap  = '{7'd64, 7'd0, 7'd37, 7'd127, 7'd10, 7'd9, 7'd23, 7'd65};
    phase_mode = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                   IDLE_NONE, IDLE_BOTH, IDLE_SEND, IDLE_RECV};

    rst_n           <= 1'b0;
    cfg_we          <= 1'b0;
    cfg_wdata       <= '0;
    acc_if.valid    <= 1'b0;
    acc_if.page_key <= '0;
    acc_if.is_last  <= 1'b0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: key extremes at reset capacity, then re-hits in the in region
    send_access(32'h8000_0000, 1'b0);
    send_access(32'h7FFF_FFFF, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'hFFFF_FFFF, 1'b0);
    send_access(32'h0000_0000, 1'b0);
    send_access(32'h8000_0000, 1'b1);
    drain_results();

    // Capacity below range clamps to ten: main 2, in 2, out 6
    write_capacity(7'd0);
    send_access(32'h0000_0011, 1'b0);
    send_access(32'h0000_0022, 1'b0);
    send_access(32'h0000_0033, 1'b0);  // in full: 11 ages into out
    send_access(32'h0000_0044, 1'b0);  // 22 into out
    send_access(32'h0000_0011, 1'b0);  // out hit, promoted to main
    send_access(32'h0000_0011, 1'b0);  // main hit
    send_access(32'h0000_0044, 1'b0);  // in hit
    send_access(32'h0000_0022, 1'b0);  // out hit, main now full
    send_access(32'h0000_0033, 1'b0);  // in hit
    send_access(32'h0000_0055, 1'b0);  // 44 into out
    send_access(32'h0000_0066, 1'b0);  // 33 into out
    send_access(32'h0000_0044, 1'b1);  // out hit, main drops 11
    drain_results();

    // Capacity above range clamps to the full store; the write also empties
    // every region, so a key seen before misses again
    write_capacity(7'd127);
    send_access(32'h0000_0044, 1'b0);
    send_access(32'h0000_0011, 1'b1);
    drain_results();

    for (int p = 0; p < NUM_PHASES; p++) begin
      write_capacity(phase_cap[p]);
      idle_mode = phase_mode[p];
      // sender keeps offering while results are held off, so the block
      // backs up and drops ready on the access port
      if (p == PRESSURE_PH) hold_request = 1'b1;
      run_phase(phase_cap[p], PHASE_ITEMS);
    end

    idle_mode = IDLE_NONE;
    repeat (8) @(posedge clk);

    if (err_count == 0 && pending == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
